/* rtl/cef_pkg.sv */
// Shared types, constants and gain table builder for the clip edge fade block.
package cef_pkg;

    // Fixed sizes of the block.
    localparam int MAX_CHANNELS       = 8;
    localparam int SINE_TABLE_ENTRIES = 1024;
    localparam int GAIN_BITS          = 16;

    // Field widths.
    localparam int SAMPLE_W  = 24;
    localparam int FRAME_W   = 30;
    localparam int FADE_W    = 20;
    localparam int CHAN_W    = 4;
    localparam int CHPOS_W   = 3;
    localparam int PHASE_W   = 17;
    localparam int PHASE_FRAC = 16;
    localparam int IDX_W     = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int IDX_SHIFT = PHASE_FRAC - $clog2(SINE_TABLE_ENTRIES);
    localparam int PROD_W    = SAMPLE_W + GAIN_BITS + 1;
    localparam int DIVCNT_W  = $clog2(PHASE_W);

    localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};
    localparam longint HALF_PI_Q30 = 64'd1686629713;

    // Configuration register indexes.
    localparam logic REG_CHANNELS    = 1'b0;
    localparam logic REG_FADE_FRAMES = 1'b1;

    // Region codes on the result word.
    typedef enum logic [1:0] {
        REGION_FADE_IN  = 2'd0,
        REGION_MIDDLE   = 2'd1,
        REGION_FADE_OUT = 2'd2
    } region_t;

    // One classified word passed from the front to the back.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        region_t                    region;
        logic [FADE_W-1:0]          k;
        logic [FADE_W-1:0]          fade;
        logic                       chan0;
    } item_t;

    typedef logic [GAIN_BITS-1:0] gain_table_t [0:SINE_TABLE_ENTRIES];

    // Quotient of two non-negative values by shift and subtract.
    function automatic longint udiv_q(longint num, longint den);
        longint q;
        longint r;
        int     b;
        q = 0;
        r = 0;
        for (b = 62; b >= 0; b--)
        begin
            r = (r <<< 1) | ((num >>> b) & longint'(1));
            if (r >= den)
            begin
                r = r - den;
                q = q | (longint'(1) <<< b);
            end
        end
        return q;
    endfunction

    // Sine of a Q30 angle in the first quadrant, by a truncated series.
    function automatic longint sine_q30(longint x);
        longint term;
        longint sum;
        longint div;
        int     n;
        term = x;
        sum  = x;
        for (n = 1; n <= 10; n++) begin
            term = (term * x) >>> 30;
            term = (term * x) >>> 30;
            div  = longint'(2 * n) * longint'(2 * n + 1);
            term = udiv_q(term, div);
            if (n % 2 == 1) sum = sum - term;
            else sum = sum + term;
        end
        if (sum < 0) sum = 0;
        if (sum > (longint'(1) <<< 30)) sum = longint'(1) <<< 30;
        return sum;
    endfunction

    // Quarter-wave gain table, evaluated at elaboration.
    function automatic gain_table_t build_gain_table();
        gain_table_t tbl;
        longint      x;
        longint      g;
        longint      maxg;
        int          i;
        maxg = (longint'(1) <<< GAIN_BITS) - 1;
        for (i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
            x = longint'(i) * HALF_PI_Q30 / SINE_TABLE_ENTRIES;
            g = (sine_q30(x) + (longint'(1) <<< (29 - GAIN_BITS))) >>> (30 - GAIN_BITS);
            if (g > maxg) g = maxg;
            tbl[i] = g[GAIN_BITS-1:0];
        end
        return tbl;
    endfunction

endpackage

/* rtl/cef_queue.sv */
// Two-entry word queue between the front and the back.
module cef_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cef_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output cef_pkg::item_t head
);
    import cef_pkg::*;

    item_t      slot_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)      count_reg <= count_reg + 2'd1;
            else if (pop && !push) count_reg <= count_reg - 2'd1;
        end
    end

endmodule

/* rtl/cef_front.sv */
// Front end: configuration, clip tracking and region classification of each word.
module cef_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic                                  cfg_index,
    input  logic [cef_pkg::FADE_W-1:0]            cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [cef_pkg::SAMPLE_W-1:0]   sample,
    input  logic [cef_pkg::FRAME_W-1:0]           clip_frames,
    input  logic                                  first_of_clip,
    input  logic                                  q_full,
    output logic                                  push,
    output cef_pkg::item_t                        push_item
);
    import cef_pkg::*;

    logic [CHAN_W-1:0]  channels_reg;
    logic [FADE_W-1:0]  fade_frames_reg;
    logic [CHPOS_W-1:0] channel_pos_reg;
    logic [FRAME_W-1:0] frame_pos_reg;
    logic [FADE_W-1:0]  fade_count_reg;
    logic [FRAME_W-1:0] tail_start_reg;

    logic [FRAME_W-1:0] half;
    logic [FADE_W-1:0]  fade_eff;
    logic [FRAME_W-1:0] tail_eff;
    logic [FRAME_W-1:0] frame_eff;
    logic [CHPOS_W-1:0] chan_eff;
    logic [FRAME_W-1:0] tail_off;
    logic [CHAN_W-1:0]  nch;
    logic [CHAN_W-1:0]  chan_sum;
    region_t            region_c;
    logic [FADE_W-1:0]  k_c;
    logic [CHPOS_W-1:0] channel_pos_next;
    logic [FRAME_W-1:0] frame_pos_next;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign push      = in_valid && in_ready;

    // Clip values in force for this word: fresh ones on the first word of a clip.
    always_comb
    begin
        half = clip_frames >> 1;
        if (first_of_clip)
        begin
            if (FRAME_W'(fade_frames_reg) < half) fade_eff = fade_frames_reg;
            else fade_eff = half[FADE_W-1:0];
            tail_eff  = clip_frames - FRAME_W'(fade_eff);
            frame_eff = '0;
            chan_eff  = '0;
        end
        else
        begin
            fade_eff  = fade_count_reg;
            tail_eff  = tail_start_reg;
            frame_eff = frame_pos_reg;
            chan_eff  = channel_pos_reg;
        end
    end

    // Region and frame offset within the fade.
    always_comb
    begin
        tail_off = frame_eff - tail_eff;
        if (frame_eff < FRAME_W'(fade_eff))
        begin
            region_c = REGION_FADE_IN;
            k_c      = frame_eff[FADE_W-1:0];
        end
        else if (frame_eff >= tail_eff && tail_off < FRAME_W'(fade_eff))
        begin
            region_c = REGION_FADE_OUT;
            k_c      = tail_off[FADE_W-1:0];
        end
        else
        begin
            region_c = REGION_MIDDLE;
            k_c      = '0;
        end
    end

    // Channel and frame advance.
    always_comb
    begin
        if (channels_reg == '0) nch = CHAN_W'(1);
        else if (channels_reg > CHAN_W'(MAX_CHANNELS)) nch = CHAN_W'(MAX_CHANNELS);
        else nch = channels_reg;
        chan_sum = CHAN_W'(chan_eff) + CHAN_W'(1);
        if (chan_sum >= nch)
        begin
            channel_pos_next = '0;
            if (frame_eff < FRAME_MAX) frame_pos_next = frame_eff + FRAME_W'(1);
            else frame_pos_next = frame_eff;
        end
        else
        begin
            channel_pos_next = chan_sum[CHPOS_W-1:0];
            frame_pos_next   = frame_eff;
        end
    end

    always_comb
    begin
        push_item.sample = sample;
        push_item.region = region_c;
        push_item.k      = k_c;
        push_item.fade   = fade_eff;
        push_item.chan0  = (chan_eff == '0);
    end

    // Configuration and clip state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_reg    <= CHAN_W'(2);
            fade_frames_reg <= '0;
            channel_pos_reg <= '0;
            frame_pos_reg   <= '0;
            fade_count_reg  <= '0;
            tail_start_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CHANNELS:    channels_reg    <= cfg_data[CHAN_W-1:0];
                    REG_FADE_FRAMES: fade_frames_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if (push)
            begin
                channel_pos_reg <= channel_pos_next;
                frame_pos_reg   <= frame_pos_next;
                fade_count_reg  <= fade_eff;
                tail_start_reg  <= tail_eff;
            end
        end
    end

endmodule

/* rtl/cef_gain_rom.sv */
// Quarter-wave sine gain table with registered read.
module cef_gain_rom (
    input  logic                            clk,
    input  logic [cef_pkg::IDX_W-1:0]       addr,
    output logic [cef_pkg::GAIN_BITS-1:0]   data
);
    import cef_pkg::*;

    localparam gain_table_t GAIN_TABLE = build_gain_table();

    logic [GAIN_BITS-1:0] data_reg;

    assign data = data_reg;

    // Registered lookup; addresses past the last entry read the last entry.
    always_ff @(posedge clk)
    begin
        if (addr > IDX_W'(SINE_TABLE_ENTRIES)) data_reg <= GAIN_TABLE[SINE_TABLE_ENTRIES];
        else data_reg <= GAIN_TABLE[addr];
    end

endmodule

/* rtl/cef_back.sv */
// Back end: phase division, gain lookup, scaling with rounding and the output register.
module cef_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_not_empty,
    input  cef_pkg::item_t                        q_head,
    output logic                                  pop,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [cef_pkg::SAMPLE_W-1:0]   faded_sample,
    output logic [1:0]                            region
);
    import cef_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE, B_DIV, B_INDEX, B_LOOKUP, B_MULT, B_EMIT
    } back_state_t;

    back_state_t                state_reg;
    back_state_t                state_next;
    item_t                      item_reg;
    logic [PHASE_W-1:0]         phase_reg;
    logic [FADE_W:0]            rem_reg;
    logic                       num_bit_reg;
    logic [DIVCNT_W-1:0]        div_cnt_reg;
    logic [IDX_W-1:0]           rom_addr_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic [1:0]                 out_region_reg;

    logic                       emit;
    logic                       div_last;
    logic [FADE_W:0]            divisor;
    logic [FADE_W+1:0]          shifted;
    logic                       q_bit;
    logic [FADE_W:0]            rem_new;
    logic [FADE_W:0]            k_plus;
    logic [PHASE_W:0]           idx_sum;
    logic [PHASE_W:0]           idx_raw;
    logic [IDX_W-1:0]           idx_c;
    logic [GAIN_BITS-1:0]       gain;
    logic [PROD_W-1:0]          mag;
    logic [PROD_W-1:0]          rnd;
    logic signed [SAMPLE_W-1:0] scaled;

    assign out_valid    = out_valid_reg;
    assign faded_sample = out_sample_reg;
    assign region       = out_region_reg;

    cef_gain_rom u_rom (
        .clk  (clk),
        .addr (rom_addr_reg),
        .data (gain)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_not_empty)
                begin
                    if (q_head.chan0 && q_head.region != REGION_MIDDLE) state_next = B_DIV;
                    else state_next = B_INDEX;
                end
            end
            B_DIV:    if (div_last) state_next = B_INDEX;
            B_INDEX:  state_next = B_LOOKUP;
            B_LOOKUP: state_next = B_MULT;
            B_MULT:   state_next = B_EMIT;
            B_EMIT:   if (!out_valid_reg || out_ready) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        pop      = (state_reg == B_IDLE) && q_not_empty;
        emit     = (state_reg == B_EMIT) && (!out_valid_reg || out_ready);
        div_last = (state_reg == B_DIV) && (div_cnt_reg == '0);
    end

    // One restoring division step: numerator is (k+1) shifted up by the phase fraction.
    always_comb
    begin
        divisor = (FADE_W+1)'(item_reg.fade) + (FADE_W+1)'(1);
        shifted = {rem_reg, num_bit_reg};
        q_bit   = (shifted >= (FADE_W+2)'(divisor));
        if (q_bit) rem_new = (FADE_W+1)'(shifted - (FADE_W+2)'(divisor));
        else rem_new = shifted[FADE_W:0];
        k_plus  = (FADE_W+1)'(q_head.k) + (FADE_W+1)'(1);
    end

    // Table index, mirrored for the fade out.
    always_comb
    begin
        idx_sum = (PHASE_W+1)'(phase_reg) + (PHASE_W+1)'(1 << (IDX_SHIFT - 1));
        idx_raw = idx_sum >> IDX_SHIFT;
        if (idx_raw > (PHASE_W+1)'(SINE_TABLE_ENTRIES)) idx_c = IDX_W'(SINE_TABLE_ENTRIES);
        else idx_c = idx_raw[IDX_W-1:0];
        if (item_reg.region == REGION_FADE_OUT) idx_c = IDX_W'(SINE_TABLE_ENTRIES) - idx_c;
    end

    // Round half away from zero and saturate to Q1.23.
    always_comb
    begin
        if (prod_reg < 0) mag = PROD_W'(-prod_reg);
        else mag = PROD_W'(prod_reg);
        rnd = (mag + PROD_W'(1 << (GAIN_BITS - 1))) >> GAIN_BITS;
        if (prod_reg < 0)
        begin
            if (rnd > PROD_W'(1 << (SAMPLE_W - 1))) scaled = {1'b1, {(SAMPLE_W-1){1'b0}}};
            else scaled = SAMPLE_W'(-rnd);
        end
        else
        begin
            if (rnd > PROD_W'((1 << (SAMPLE_W - 1)) - 1)) scaled = {1'b0, {(SAMPLE_W-1){1'b1}}};
            else scaled = rnd[SAMPLE_W-1:0];
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg    <= q_head;
            rem_reg     <= k_plus >> 1;
            num_bit_reg <= k_plus[0];
            div_cnt_reg <= DIVCNT_W'(PHASE_W - 1);
        end
        if (state_reg == B_DIV)
        begin
            rem_reg     <= rem_new;
            num_bit_reg <= 1'b0;
            div_cnt_reg <= div_cnt_reg - DIVCNT_W'(1);
        end
        if (state_reg == B_INDEX)
        begin
            rom_addr_reg <= idx_c;
        end
        if (state_reg == B_MULT)
        begin
            prod_reg <= PROD_W'(item_reg.sample) * $signed({1'b0, gain});
        end
        if (emit)
        begin
            if (item_reg.region == REGION_MIDDLE) out_sample_reg <= item_reg.sample;
            else out_sample_reg <= scaled;
            out_region_reg <= item_reg.region;
        end
    end

    // Sequencer state and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    // Phase is cleared at the start of each frame and filled by the divider.
    always_ff @(posedge clk)
    begin
        if (pop && q_head.chan0 && q_head.region == REGION_MIDDLE)
        begin
            phase_reg <= '0;
        end
        else if (pop && q_head.chan0)
        begin
            phase_reg <= '0;
        end
        else if (state_reg == B_DIV)
        begin
            phase_reg <= {phase_reg[PHASE_W-2:0], q_bit};
        end
    end

endmodule

/* rtl/clip_edge_fade_core.sv */
// Top level of the clip edge fade: front, word queue and back.
// In the back end every word is popped from the queue; a word of a fade frame's first
// channel then runs the 17-step phase divider, and every word then passes the table
// address, table read, multiply and output steps. A two-word queue lets the front take
// words while the back is busy, and the output register holds a result until it is taken.
// Region codes: 0 fade in, 1 untouched middle, 2 fade out. Configuration index 0
// (channels) applies from the next word; index 1 (fade frames) applies from the next
// first sample of a clip.
module clip_edge_fade_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic                                  cfg_index,
    input  logic [cef_pkg::FADE_W-1:0]            cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [cef_pkg::SAMPLE_W-1:0]   sample,
    input  logic [cef_pkg::FRAME_W-1:0]           clip_frames,
    input  logic                                  first_of_clip,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [cef_pkg::SAMPLE_W-1:0]   faded_sample,
    output logic [1:0]                            region
);
    import cef_pkg::*;

    logic  q_full;
    logic  push;
    item_t push_item;
    logic  pop;
    logic  q_not_empty;
    item_t q_head;

    cef_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .clip_frames   (clip_frames),
        .first_of_clip (first_of_clip),
        .q_full        (q_full),
        .push          (push),
        .push_item     (push_item)
    );

    cef_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    cef_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .faded_sample (faded_sample),
        .region       (region)
    );

endmodule
